// ===== hw/rtl/quality_score_huffman_encoder_assert.svh =====
// assertion macros for the quality score huffman encoder
// no dependencies; taken in by `include in the modules that check their own logic
`ifndef QUALITY_SCORE_HUFFMAN_ENCODER_ASSERT_SVH
`define QUALITY_SCORE_HUFFMAN_ENCODER_ASSERT_SVH

`ifndef SYNTH
`define QSHE_ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed: implication");
`define QSHE_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed: next cycle");
`define QSHE_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed: forbidden condition");
`else
`define QSHE_ASSERT_IMPLIES(label, clk, rst, cond, expr)
`define QSHE_ASSERT_NEXT(label, clk, rst, cond, expr)
`define QSHE_ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

// ===== hw/rtl/qshe_pkg.sv =====
// shared constants, types and the prefix code table of the quality score encoder
// no dependencies
package qshe_pkg;

   localparam int OutBits     = 8;
   localparam int SymbolWidth = 8;
   localparam int MaxCodeLen  = 14;
   localparam int LenWidth    = $clog2(MaxCodeLen + 1);
   localparam int PendWidth   = OutBits - 1;
   localparam int PendCntWidth = $clog2(OutBits);
   localparam int CatWidth    = PendWidth + MaxCodeLen;
   localparam int CountWidth  = $clog2(CatWidth + 1);
   localparam int MaxResults  = (CatWidth + OutBits - 1) / OutBits;
   localparam int ResIdxWidth = $clog2(MaxResults + 1);
   localparam int AlignWidth  = MaxResults * OutBits;
   localparam int ValidWidth  = 4;
   localparam int QueueDepth  = 4;
   localparam int QPtrWidth   = $clog2(QueueDepth);
   localparam int QCntWidth   = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic                  hit;
      logic [MaxCodeLen-1:0] bits;
      logic [LenWidth-1:0]   len;
   } code_type;

   // one queued transaction: left aligned bytes and how to tag them
   typedef struct packed {
      logic [AlignWidth-1:0]  data;
      logic [ResIdxWidth-1:0] count;
      logic [ValidWidth-1:0]  last_valid;
      logic                   last_final;
   } entry_type;

   function automatic code_type code_lookup(input logic [SymbolWidth-1:0] sym);
      code_type c;
      c.hit = 1'b1;
      unique case (sym)
         8'h48: begin c.bits = 14'd0;     c.len = 4'd1;  end // H
         8'h47: begin c.bits = 14'd4;     c.len = 4'd3;  end // G
         8'h43: begin c.bits = 14'd20;    c.len = 4'd5;  end // C
         8'h41: begin c.bits = 14'd42;    c.len = 4'd6;  end // A
         8'h3C: begin c.bits = 14'd86;    c.len = 4'd7;  end // <
         8'h39: begin c.bits = 14'd174;   c.len = 4'd8;  end // 9
         8'h3A: begin c.bits = 14'd175;   c.len = 4'd8;  end // :
         8'h42: begin c.bits = 14'd22;    c.len = 4'd5;  end // B
         8'h3E: begin c.bits = 14'd92;    c.len = 4'd7;  end // >
         8'h2E: begin c.bits = 14'd744;   c.len = 4'd10; end // .
         8'h29: begin c.bits = 14'd2980;  c.len = 4'd12; end // )
         8'h49: begin c.bits = 14'd2981;  c.len = 4'd12; end // I
         8'h2B: begin c.bits = 14'd1491;  c.len = 4'd11; end // +
         8'h36: begin c.bits = 14'd373;   c.len = 4'd9;  end // 6
         8'h3B: begin c.bits = 14'd187;   c.len = 4'd8;  end // ;
         8'h23: begin c.bits = 14'd47;    c.len = 4'd6;  end // #
         8'h46: begin c.bits = 14'd6;     c.len = 4'd3;  end // F
         8'h45: begin c.bits = 14'd14;    c.len = 4'd4;  end // E
         8'h44: begin c.bits = 14'd30;    c.len = 4'd5;  end // D
         8'h32: begin c.bits = 14'd992;   c.len = 4'd10; end // 2
         8'h2C: begin c.bits = 14'd1986;  c.len = 4'd11; end // ,
         8'h2F: begin c.bits = 14'd1987;  c.len = 4'd11; end // /
         8'h38: begin c.bits = 14'd497;   c.len = 4'd9;  end // 8
         8'h35: begin c.bits = 14'd498;   c.len = 4'd9;  end // 5
         8'h37: begin c.bits = 14'd499;   c.len = 4'd9;  end // 7
         8'h3F: begin c.bits = 14'd125;   c.len = 4'd7;  end // ?
         8'h3D: begin c.bits = 14'd252;   c.len = 4'd8;  end // =
         8'h33: begin c.bits = 14'd1012;  c.len = 4'd10; end // 3
         8'h28: begin c.bits = 14'd4052;  c.len = 4'd12; end // (
         8'h2A: begin c.bits = 14'd4053;  c.len = 4'd12; end // *
         8'h25: begin c.bits = 14'd16216; c.len = 4'd14; end // %
         8'h26: begin c.bits = 14'd16217; c.len = 4'd14; end // &
         8'h27: begin c.bits = 14'd8109;  c.len = 4'd13; end // '
         8'h2D: begin c.bits = 14'd4055;  c.len = 4'd12; end // -
         8'h34: begin c.bits = 14'd1014;  c.len = 4'd10; end // 4
         8'h30: begin c.bits = 14'd2030;  c.len = 4'd11; end // 0
         8'h31: begin c.bits = 14'd2031;  c.len = 4'd11; end // 1
         8'h40: begin c.bits = 14'd127;   c.len = 4'd7;  end // @
         default: begin
            c.hit  = 1'b0;
            c.bits = '0;
            c.len  = '0;
         end
      endcase
      return c;
   endfunction

endpackage

// ===== hw/rtl/qshe_req_if.sv =====
// input channel of the quality score encoder: one character per transaction
// depends on qshe_pkg
interface qshe_req_if;
   logic                              valid;
   logic                              ready;
   logic [qshe_pkg::SymbolWidth-1:0]  symbol;
   logic                              end_of_stream;

   modport source (output valid, symbol, end_of_stream, input ready);
   modport sink   (input valid, symbol, end_of_stream, output ready);
endinterface

// ===== hw/rtl/qshe_rsp_if.sv =====
// result channel of the quality score encoder: one packed byte per transaction
// depends on qshe_pkg
interface qshe_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [qshe_pkg::OutBits-1:0]     byte_value;
   logic [qshe_pkg::ValidWidth-1:0]  valid_bits;
   logic                             stream_final;
   logic                             run_last;

   modport source (output valid, byte_value, valid_bits, stream_final, run_last, input ready);
   modport sink   (input valid, byte_value, valid_bits, stream_final, run_last, output ready);
endinterface

// ===== hw/rtl/quality_score_huffman_encoder.sv =====
// Quality score huffman encoder. Each req transaction carries one character, which is
// looked up in a fixed 38-entry prefix code (1 to 14 bits) and appended msb first to a
// bit packer; every full byte leaves as one rsp transaction, and end_of_stream pads the
// remaining bits with zeros into a final short byte (valid_bits tells how many count).
// Characters outside the code add no bits. A character is accepted every cycle as long
// as the four-entry queue between the front end and the byte emitter has room; the
// emitter sends one byte per cycle while the receiver does not stall it, so a character
// that completes two or three bytes holds the emitter for each of them and the sustained
// rate is set by output bytes, one per cycle. The first byte of a character is written
// into a queue slot when the character is accepted, can wait there while the output is
// stalled, and then moves into the output register. run_last marks the last byte
// caused by a character; characters that complete no byte produce no rsp transaction.
// depends on qshe_pkg, qshe_req_if, qshe_rsp_if, qshe_front, qshe_queue, qshe_back

module quality_score_huffman_encoder (
   input  logic       clock,
   input  logic       reset,
   qshe_req_if.sink   req_chan,
   qshe_rsp_if.source rsp_chan
);

   // front end to queue
   qshe_pkg::entry_type push_entry;
   logic                push_valid;
   logic                push_ready;

   // queue to byte emitter
   qshe_pkg::entry_type pop_entry;
   logic                pop_valid;
   logic                pop;

   // lookup and packing, one character per cycle while the queue has room
   qshe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_entry (push_entry),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   // decouples character intake from byte output
   qshe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_entry (push_entry),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_entry  (pop_entry),
      .pop_valid  (pop_valid),
      .pop        (pop)
   );

   // one byte per cycle into the output register while the receiver does not stall it
   qshe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry       (pop_entry),
      .entry_valid (pop_valid),
      .pop         (pop),
      .rsp_chan    (rsp_chan)
   );

endmodule

// ===== hw/rtl/qshe_front.sv =====
// front end: code lookup, bit packing state and byte split of each character
// depends on qshe_pkg, qshe_req_if and the assertion header
`include "quality_score_huffman_encoder_assert.svh"

module qshe_front (
   input  logic                clock,
   input  logic                reset,
   qshe_req_if.sink            req_chan,
   output qshe_pkg::entry_type push_entry,
   output logic                push_valid,
   input  logic                push_ready
);

   logic [qshe_pkg::PendWidth-1:0]    pend_bits_ff, pend_bits_in;
   logic [qshe_pkg::PendCntWidth-1:0] pend_cnt_ff, pend_cnt_in;

   qshe_pkg::code_type                code;
   logic [qshe_pkg::LenWidth-1:0]     len;
   logic [qshe_pkg::CatWidth-1:0]     cat;
   logic [qshe_pkg::CountWidth-1:0]   total;
   logic [qshe_pkg::CountWidth-1:0]   align_shift;
   logic [qshe_pkg::ResIdxWidth-1:0]  n_full;
   logic [qshe_pkg::PendCntWidth-1:0] rest;
   logic [qshe_pkg::PendWidth:0]      rest_mask;
   logic                              pad;
   logic                              accept;

   assign req_chan.ready = push_ready;
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      code  = qshe_pkg::code_lookup(req_chan.symbol);
      len   = code.hit ? code.len : '0;
      cat   = (qshe_pkg::CatWidth'(pend_bits_ff) << len) |
              qshe_pkg::CatWidth'(code.bits);
      total = qshe_pkg::CountWidth'(pend_cnt_ff) + qshe_pkg::CountWidth'(len);
      n_full = qshe_pkg::ResIdxWidth'(total / qshe_pkg::OutBits);
      rest   = qshe_pkg::PendCntWidth'(total % qshe_pkg::OutBits);
      pad    = req_chan.end_of_stream && (rest != '0);
      align_shift = qshe_pkg::CountWidth'(qshe_pkg::AlignWidth) - total;

      push_entry.data       = qshe_pkg::AlignWidth'(cat) << align_shift;
      push_entry.count      = n_full + qshe_pkg::ResIdxWidth'(pad);
      push_entry.last_valid = pad ? qshe_pkg::ValidWidth'(rest)
                                  : qshe_pkg::ValidWidth'(qshe_pkg::OutBits);
      push_entry.last_final = req_chan.end_of_stream;
      push_valid = accept && (push_entry.count != '0);

      // keep only the bits left over below the emitted bytes
      rest_mask = ((qshe_pkg::PendWidth + 1)'(1) << rest) - 1'b1;
      pend_bits_in = pend_bits_ff;
      pend_cnt_in  = pend_cnt_ff;
      if (accept) begin
         if (req_chan.end_of_stream) begin
            pend_bits_in = '0;
            pend_cnt_in  = '0;
         end else begin
            pend_bits_in = cat[qshe_pkg::PendWidth-1:0] & rest_mask[qshe_pkg::PendWidth-1:0];
            pend_cnt_in  = rest;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bits_ff <= '0;
         pend_cnt_ff  <= '0;
      end else begin
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
      end
   end

   `QSHE_ASSERT_NEXT(flush_clears_pending, clock, reset, accept && req_chan.end_of_stream, pend_cnt_ff == '0 && pend_bits_ff == '0)
   `QSHE_ASSERT_NEVER(push_while_full, clock, reset, push_valid && !push_ready)

endmodule

// ===== hw/rtl/qshe_queue.sv =====
// short register queue between the front end and the byte emitter
// depends on qshe_pkg and the assertion header
`include "quality_score_huffman_encoder_assert.svh"

module qshe_queue (
   input  logic                clock,
   input  logic                reset,
   input  qshe_pkg::entry_type push_entry,
   input  logic                push_valid,
   output logic                push_ready,
   output qshe_pkg::entry_type pop_entry,
   output logic                pop_valid,
   input  logic                pop
);

   qshe_pkg::entry_type               slot_ff [qshe_pkg::QueueDepth];
   logic [qshe_pkg::QPtrWidth-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [qshe_pkg::QPtrWidth-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [qshe_pkg::QCntWidth-1:0]    fill_ff, fill_in;
   logic                              do_push;
   logic                              do_pop;

   assign push_ready = fill_ff != qshe_pkg::QCntWidth'(qshe_pkg::QueueDepth);
   assign pop_valid  = fill_ff != '0;
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + qshe_pkg::QCntWidth'(do_push) - qshe_pkg::QCntWidth'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `QSHE_ASSERT_NEVER(pop_when_empty, clock, reset, pop && !pop_valid)
   `QSHE_ASSERT_IMPLIES(fill_matches_ptrs, clock, reset, fill_ff != qshe_pkg::QCntWidth'(qshe_pkg::QueueDepth), wr_ptr_ff == rd_ptr_ff + qshe_pkg::QPtrWidth'(fill_ff))

endmodule

// ===== hw/rtl/qshe_back.sv =====
// back end: walks the bytes of each queued transaction into the output register
// depends on qshe_pkg, qshe_rsp_if and the assertion header
`include "quality_score_huffman_encoder_assert.svh"

module qshe_back (
   input  logic                clock,
   input  logic                reset,
   input  qshe_pkg::entry_type entry,
   input  logic                entry_valid,
   output logic                pop,
   qshe_rsp_if.source          rsp_chan
);

   logic [qshe_pkg::ResIdxWidth-1:0] idx_ff, idx_in;
   logic [qshe_pkg::ResIdxWidth-1:0] idx_next;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [qshe_pkg::OutBits-1:0]     byte_ff;
   logic [qshe_pkg::ValidWidth-1:0]  vbits_ff;
   logic                             final_ff;
   logic                             last_ff;
   logic [qshe_pkg::AlignWidth-1:0]  shifted;
   logic                             load;
   logic                             is_last;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.byte_value   = byte_ff;
   assign rsp_chan.valid_bits   = vbits_ff;
   assign rsp_chan.stream_final = final_ff;
   assign rsp_chan.run_last     = last_ff;

   always_comb begin
      load     = entry_valid && (!rsp_valid_ff || rsp_chan.ready);
      idx_next = idx_ff + 1'b1;
      is_last  = idx_next == entry.count;
      pop      = load && is_last;
      shifted  = entry.data << (int'(idx_ff) * qshe_pkg::OutBits);
      idx_in   = idx_ff;
      if (load) begin
         idx_in = is_last ? '0 : idx_next;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff  <= shifted[qshe_pkg::AlignWidth-1 -: qshe_pkg::OutBits];
         vbits_ff <= is_last ? entry.last_valid : qshe_pkg::ValidWidth'(qshe_pkg::OutBits);
         final_ff <= is_last && entry.last_final;
         last_ff  <= is_last;
      end
   end

   `QSHE_ASSERT_IMPLIES(idx_in_range, clock, reset, entry_valid, idx_ff < entry.count)
   `QSHE_ASSERT_IMPLIES(partial_entry_held, clock, reset, idx_ff != '0, entry_valid)

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// testbench for quality_score_huffman_encoder: directed and random characters, bytes checked
// against a prefix code packer kept inside the bench; depends on qshe_pkg, qshe_req_if, qshe_rsp_if
module tb;

   // one character transaction as the bench queues it
   typedef struct {
      logic [qshe_pkg::SymbolWidth-1:0] symbol;
      logic                             end_of_stream;
   } char_item_type;

   // one packed byte as the encoder should send it
   typedef struct packed {
      logic [qshe_pkg::OutBits-1:0]    byte_value;
      logic [qshe_pkg::ValidWidth-1:0] valid_bits;
      logic                            stream_final;
      logic                            run_last;
   } packed_byte_type;

   localparam int NumCodes    = 38;
   localparam int AccWidth    = qshe_pkg::OutBits - 1 + 14;
   localparam int TailCycles  = 20;

   // quality character prefix code: character, code bits, code length
   logic [7:0]  code_char [NumCodes] = '{
      "H", "G", "C", "A", "<", "9", ":", "B", ">", ".", ")", "I", "+",
      "6", ";", "#", "F", "E", "D", "2", ",", "/", "8", "5", "7", "?",
      "=", "3", "(", "*", "%", "&", "'", "-", "4", "0", "1", "@"};
   logic [13:0] code_bits [NumCodes] = '{
      14'd0, 14'd4, 14'd20, 14'd42, 14'd86, 14'd174, 14'd175, 14'd22, 14'd92,
      14'd744, 14'd2980, 14'd2981, 14'd1491, 14'd373, 14'd187, 14'd47, 14'd6,
      14'd14, 14'd30, 14'd992, 14'd1986, 14'd1987, 14'd497, 14'd498, 14'd499,
      14'd125, 14'd252, 14'd1012, 14'd4052, 14'd4053, 14'd16216, 14'd16217,
      14'd8109, 14'd4055, 14'd1014, 14'd2030, 14'd2031, 14'd127};
   int          code_len  [NumCodes] = '{
      1, 3, 5, 6, 7, 8, 8, 5, 7, 10, 12, 12, 11, 9, 8, 6, 3, 4, 5, 10, 11, 11,
      9, 9, 9, 7, 8, 10, 12, 12, 14, 14, 13, 12, 10, 11, 11, 7};

   logic clock = 1'b0;
   logic reset;

   qshe_req_if req_chan ();
   qshe_rsp_if rsp_chan ();

   quality_score_huffman_encoder u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #4 clock = ~clock;

   char_item_type   char_queue [$];     // characters waiting to be driven
   packed_byte_type expected_bytes [$]; // bytes predicted but not yet seen
   char_item_type   next_char;
   packed_byte_type want_byte;
   logic [qshe_pkg::OutBits-2:0] pend_bits; // packer bits not yet sent, right aligned
   int              pend_cnt;
   int              idle_pct;
   int              stall_pct;
   bit              req_taken;
   bit              failed;

   // append one character's code to the packer and queue the bytes it completes
   function automatic void encode_symbol(input logic [qshe_pkg::SymbolWidth-1:0] sym,
                                         input logic eos);
      logic [AccWidth-1:0] acc;
      logic [AccWidth-1:0] shifted;
      int                  cnt;
      int                  rest;
      packed_byte_type     word;
      packed_byte_type     emitted [$];
      acc = AccWidth'(pend_bits);
      cnt = pend_cnt;
      // characters outside the code add nothing
      for (int i = 0; i < NumCodes; i++) begin
         if (code_char[i] == sym) begin
            acc = (acc << code_len[i]) | AccWidth'(code_bits[i]);
            cnt = cnt + code_len[i];
            break;
         end
      end
      // every full byte leaves, oldest bits first
      while (cnt >= qshe_pkg::OutBits) begin
         rest              = cnt - qshe_pkg::OutBits;
         shifted           = acc >> rest;
         word.byte_value   = shifted[qshe_pkg::OutBits-1:0];
         word.valid_bits   = qshe_pkg::ValidWidth'(qshe_pkg::OutBits);
         word.stream_final = 1'b0;
         word.run_last     = 1'b0;
         emitted.push_back(word);
         cnt = rest;
         acc = acc & ((AccWidth'(1) << rest) - 1);
      end
      if (eos) begin
         if (cnt > 0) begin
            // zero padded short byte closes the stream
            shifted           = acc << (qshe_pkg::OutBits - cnt);
            word.byte_value   = shifted[qshe_pkg::OutBits-1:0];
            word.valid_bits   = qshe_pkg::ValidWidth'(cnt);
            word.stream_final = 1'b1;
            word.run_last     = 1'b0;
            emitted.push_back(word);
         end else if (emitted.size() > 0) begin
            // stream ended on a byte boundary: last full byte closes it
            emitted[emitted.size()-1].stream_final = 1'b1;
         end
         acc = '0;
         cnt = 0;
      end
      if (emitted.size() > 0)
         emitted[emitted.size()-1].run_last = 1'b1;
      foreach (emitted[k])
         expected_bytes.push_back(emitted[k]);
      pend_bits = acc[qshe_pkg::OutBits-2:0];
      pend_cnt  = cnt;
   endfunction

   task automatic queue_char(input logic [qshe_pkg::SymbolWidth-1:0] sym, input logic eos);
      char_item_type item;
      item.symbol        = sym;
      item.end_of_stream = eos;
      char_queue.push_back(item);
   endtask

   // mostly table characters, some raw noise, streams of random length
   task automatic queue_random(input int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 85)
            queue_char(code_char[$urandom_range(NumCodes - 1)], $urandom_range(11) == 0);
         else
            queue_char(qshe_pkg::SymbolWidth'($urandom_range(255)), $urandom_range(11) == 0);
      end
   endtask

   // sender holds off until every queued character is taken and every byte is back
   task automatic wait_drained();
      while (char_queue.size() != 0 || req_chan.valid)
         @(posedge clock);
      while (expected_bytes.size() != 0)
         @(posedge clock);
   endtask

   task automatic check_field(input string label, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, label, want, got);
         failed = 1'b1;
      end
   endtask

   // input side: every accepted character goes through the predictor
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         encode_symbol(req_chan.symbol, req_chan.end_of_stream);
         req_taken = 1'b1;
      end
   end

   // driver: new transaction on the falling edge once the previous one is taken
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         req_taken = 1'b0;
         if (char_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
            next_char = char_queue.pop_front();
            req_chan.valid         <= 1'b1;
            req_chan.symbol        <= next_char.symbol;
            req_chan.end_of_stream <= next_char.end_of_stream;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // receiver back pressure
   always @(negedge clock) begin
      rsp_chan.ready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   // monitor: each byte against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected byte, expected none actual %h/%0d final %b last %b",
                     $time, rsp_chan.byte_value, rsp_chan.valid_bits,
                     rsp_chan.stream_final, rsp_chan.run_last);
            failed = 1'b1;
         end else begin
            want_byte = expected_bytes.pop_front();
            check_field("byte_value", want_byte.byte_value, rsp_chan.byte_value);
            check_field("valid_bits", 8'(want_byte.valid_bits), 8'(rsp_chan.valid_bits));
            check_field("stream_final", 8'(want_byte.stream_final), 8'(rsp_chan.stream_final));
            check_field("run_last", 8'(want_byte.run_last), 8'(rsp_chan.run_last));
         end
      end
   end

   initial begin
      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.symbol        = '0;
      req_chan.end_of_stream = 1'b0;
      rsp_chan.ready         = 1'b0;
      idle_pct               = 0;
      stall_pct              = 0;
      pend_bits              = '0;
      pend_cnt               = 0;
      req_taken              = 1'b0;
      failed                 = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed part, no idling
      queue_char(8'h00, 1'b0);   // lowest code, not in the table
      queue_char(8'hFF, 1'b1);   // flush with nothing pending and nothing sent
      queue_char("H", 1'b1);     // single bit padded to a byte
      queue_char("9", 1'b1);     // flush exactly on a byte boundary
      queue_char("<", 1'b0);
      queue_char("%", 1'b1);     // longest code on 7 pending bits: three bytes
      queue_char("@", 1'b0);
      queue_char("&", 1'b0);     // two full bytes, five left over
      queue_char(8'hFF, 1'b1);   // unknown character still flushes pending bits
      queue_char("E", 1'b0);
      queue_char("E", 1'b1);     // boundary reached by this very character
      queue_char("'", 1'b1);     // 13 bit code: one full and one short byte
      queue_char("&", 1'b0);
      queue_char("H", 1'b0);
      queue_char("H", 1'b1);     // last full byte carries the stream end
      queue_char(8'h80, 1'b0);
      queue_char(8'h7F, 1'b0);
      queue_char("%", 1'b0);
      queue_char(")", 1'b1);
      wait_drained();

      // random phases with different idle and stall mixes
      queue_random(62);
      wait_drained();
      idle_pct  = 75;
      queue_random(62);
      wait_drained();
      idle_pct  = 0;
      stall_pct = 75;
      queue_random(62);
      wait_drained();
      idle_pct  = 11;
      stall_pct = 11;
      queue_random(64);
      wait_drained();

      // trailing cycles catch stray bytes
      repeat (TailCycles) @(posedge clock);
      if (!failed && expected_bytes.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // hang guard
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/qshe_pkg.sv
hw/rtl/qshe_req_if.sv
hw/rtl/qshe_rsp_if.sv
hw/rtl/qshe_front.sv
hw/rtl/qshe_queue.sv
hw/rtl/qshe_back.sv
hw/rtl/quality_score_huffman_encoder.sv
bench/tb.sv
